@@ hw/rtl/tpa_pkg.sv @@
// Shared types and constants for the triangle primitive assembler.
`timescale 1ns / 1ps
`default_nettype none

package tpa_pkg;

    // Vertex index width and default depth of the command queue
    localparam int unsigned IDX_W       = 32;
    localparam int unsigned QUEUE_DEPTH = 4;

    // Primitive modes held in the configuration register
    typedef enum logic [1:0] {
        MODE_LIST  = 2'd0,
        MODE_FAN   = 2'd1,
        MODE_STRIP = 2'd2,
        MODE_BAD   = 2'd3
    } t_mode;

    // One command: up to three output indices plus tags for the back end
    typedef struct packed {
        logic [2:0][IDX_W-1:0] idx;       // indices in emit order, slot 0 first
        logic [1:0]            last_pos;  // slot of the last result (count - 1)
        logic                  valid;     // results carry real indices
        logic                  done;      // command ends the list
        logic                  err;       // unsupported mode marker
    } t_cmd;

endpackage

`default_nettype wire

@@ hw/rtl/tpa_front.sv @@
// Front end: accepts vertex indices, tracks list history and builds commands.
`timescale 1ns / 1ps
`default_nettype none

module tpa_front
    import tpa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    input  wire logic [1:0]       i_cfg_data,
    input  wire logic             i_s_tvalid,
    input  wire logic [IDX_W-1:0] i_s_tdata,
    input  wire logic             i_s_tlast,
    input  wire logic             i_q_full,
    output logic                  o_s_tready,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    t_mode            r_mode;
    logic [IDX_W-1:0] r_first, n_first;
    logic [IDX_W-1:0] r_older, n_older;
    logic [IDX_W-1:0] r_newer, n_newer;
    logic [1:0]       r_seen,  n_seen;
    logic             r_odd,   n_odd;
    logic             w_accept;
    logic             w_full;
    logic             w_emit;

    assign o_s_tready = !i_q_full;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_seen == 2'd2);

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LIST;
        end else if (i_cfg_valid) begin
            r_mode <= t_mode'(i_cfg_data);
        end
    end

    // Classify the item and build its command
    always_comb begin
        o_cmd          = '0;
        w_emit         = 1'b0;
        case (r_mode)
            MODE_LIST: begin
                o_cmd.idx[0]    = i_s_tdata;
                o_cmd.last_pos  = 2'd0;
                o_cmd.valid     = 1'b1;
                w_emit          = 1'b1;
            end
            MODE_FAN: begin
                o_cmd.idx[0]    = r_first;
                o_cmd.idx[1]    = r_newer;
                o_cmd.idx[2]    = i_s_tdata;
                o_cmd.last_pos  = 2'd2;
                o_cmd.valid     = 1'b1;
                w_emit          = w_full;
            end
            MODE_STRIP: begin
                o_cmd.idx[0]    = r_older;
                o_cmd.idx[1]    = r_odd ? i_s_tdata : r_newer;
                o_cmd.idx[2]    = r_odd ? r_newer : i_s_tdata;
                o_cmd.last_pos  = 2'd2;
                o_cmd.valid     = 1'b1;
                w_emit          = w_full;
            end
            default: begin
                o_cmd.err       = 1'b1;
                w_emit          = 1'b1;
            end
        endcase
        o_cmd.done = i_s_tlast;
        // Bare end marker when the closing item yields no triangle
        if (!w_emit) begin
            o_cmd = '0;
            o_cmd.done = 1'b1;
        end
    end

    assign o_push = w_accept && (w_emit || i_s_tlast);

    // Advance history the same way in every mode
    always_comb begin
        n_first = (r_seen == 2'd0) ? i_s_tdata : r_first;
        n_odd   = w_full ? !r_odd : r_odd;
        n_older = r_newer;
        n_newer = i_s_tdata;
        n_seen  = w_full ? r_seen : r_seen + 2'd1;
        if (i_s_tlast) begin
            n_first = '0;
            n_older = '0;
            n_newer = '0;
            n_seen  = '0;
            n_odd   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_older <= '0;
            r_newer <= '0;
            r_seen  <= '0;
            r_odd   <= 1'b0;
        end else if (w_accept) begin
            r_first <= n_first;
            r_older <= n_older;
            r_newer <= n_newer;
            r_seen  <= n_seen;
            r_odd   <= n_odd;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tpa_queue.sv @@
// Command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module tpa_queue
    import tpa_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_empty,
    output logic      o_full
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    // Pointer wrap at the queue depth and next fill count
    always_comb begin
        n_wr  = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        n_rd  = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= n_wr;
            end
            if (w_pop) begin
                r_rd <= n_rd;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tpa_back.sv @@
// Back end: serializes each command into result items through an output register.
`timescale 1ns / 1ps
`default_nettype none

module tpa_back
    import tpa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    input  wire logic             i_q_empty,
    output logic                  o_pop,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [IDX_W-1:0]      o_m_tdata,  // out_index
    output logic                  o_m_tlast,  // list_done
    output logic [2:0]            o_m_tuser   // index_valid, run_last, mode_error
);

    t_cmd             r_cmd;
    logic             r_busy, n_busy;
    logic [1:0]       r_pos,  n_pos;
    logic             r_ov;
    logic [IDX_W-1:0] r_odata;
    logic             r_olast;
    logic [2:0]       r_ouser;
    logic             w_slot;
    logic             w_emit;
    logic             w_final;

    assign w_slot  = !r_ov || i_m_tready;
    assign w_emit  = r_busy && w_slot;
    assign w_final = (r_pos == r_cmd.last_pos);
    assign o_pop   = !i_q_empty && (!r_busy || (w_emit && w_final));

    // Next position within the current command
    always_comb begin
        n_busy = r_busy;
        n_pos  = r_pos;
        if (w_emit) begin
            n_pos = r_pos + 2'd1;
            if (w_final) begin
                n_busy = 1'b0;
            end
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_pos  = 2'd0;
        end
    end

    // Command holding register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else begin
            r_busy <= n_busy;
            r_pos  <= n_pos;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_slot) begin
            r_ov <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_odata <= r_cmd.idx[r_pos];
            r_olast <= w_final && r_cmd.done;
            r_ouser <= {r_cmd.err, w_final, r_cmd.valid};
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_ouser;

    // Position stays inside the held command
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos <= r_cmd.last_pos))
        else $error("position beyond command length");

    // Markers are always single results
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_ouser[0]) |-> r_ouser[1])
        else $error("marker result not last of its run");

    // Error results never carry an index
    a_err_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ouser[2]) |-> (!r_ouser[0] && r_odata == '0))
        else $error("error result carries an index");

    // A list end is always the last result of its run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_olast) |-> r_ouser[1])
        else $error("list end not on last result");

endmodule

`default_nettype wire

@@ hw/rtl/triangle_primitive_assembler.sv @@
// Top level of the triangle primitive assembler.
// Usage:
//   Slave stream (i_s_*): one vertex index per item in tdata, tlast on the
//   last index of a list. Master stream (o_m_*): one triangle-list index per
//   item in tdata, tlast on the final result of a list, tuser carrying
//   index_valid, run_last and mode_error from bit 0 up.
//   Config channel (i_cfg_*): primitive mode, 0 list, 1 fan, 2 strip,
//   3 unsupported; always ready, write only while the block is idle.
//   The first result of an accepted item passes through the queue, the
//   command register and the output register before it is valid.
//   Throughput: list and error modes give one result per item, fan and strip
//   three once the list holds two indices; the single output register shows
//   one index per cycle while the receiver is ready and the queue is not empty.
//   Reset clears the mode to list, the history and the queue; no results
//   are pending after reset.
//   When the receiver stalls the output register holds, the back end stops,
//   and the queue fills; the slave side drops tready once it is full.
`timescale 1ns / 1ps
`default_nettype none

module triangle_primitive_assembler
    import tpa_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [1:0]       i_cfg_data,   // primitive_mode
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [IDX_W-1:0] i_s_tdata,    // vertex_index
    input  wire logic             i_s_tlast,    // list_end
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [IDX_W-1:0]      o_m_tdata,    // out_index
    output logic                  o_m_tlast,    // list_done
    output logic [2:0]            o_m_tuser     // index_valid, run_last, mode_error
);

    t_cmd w_push_cmd;
    t_cmd w_head_cmd;
    logic w_push;
    logic w_pop;
    logic w_empty;
    logic w_full;

    assign o_cfg_ready = 1'b1;

    tpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_q_full    (w_full),
        .o_s_tready  (o_s_tready),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    tpa_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    tpa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_head_cmd),
        .i_q_empty  (w_empty),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire
